/* src/dpcmdq_pkg.sv */
// ============================================================================
// dpcmdq_pkg
// Shared types and constants for the packed dpcm dequantizer.
// ============================================================================
`default_nettype none

package dpcmdq_pkg;

    localparam int unsigned POS_W = 10;
    localparam logic [10:0] POS_LIMIT = 11'd1024;

    typedef enum logic [1:0] {
        CMD_WR_SCALE = 2'd0,
        CMD_PAYLOAD  = 2'd1,
        CMD_RESTART  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_FOUR_BIT    = 3'd0,
        CFG_DELTA       = 3'd1,
        CFG_PER_CHANNEL = 3'd2,
        CFG_ELEMS       = 3'd3,
        CFG_TOKENS      = 3'd4
    } cfg_idx_t;

    // one element issued into the reconstruction pipeline
    typedef struct packed {
        logic              valid;
        logic signed [7:0] code;
        logic [POS_W-1:0]  tok;
        logic [POS_W-1:0]  ch;
        logic [POS_W-1:0]  scale_idx;
        logic              scale_zero;
        logic              use_pred;
        logic              last_run;
        logic              last_tensor;
    } elem_t;

    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] idx;
        logic [31:0]      value;
    } scale_wr_t;

    typedef struct packed {
        logic signed [31:0] recon;
        logic [POS_W-1:0]   tok;
        logic [POS_W-1:0]   ch;
        logic               last_run;
        logic               last_tensor;
    } result_t;

endpackage

`default_nettype wire

/* src/dpcmdq_recon.sv */
// ============================================================================
// dpcmdq_recon
// Scale and prediction memories, multiply, delta add with saturation and
// the output register.
// ============================================================================
`default_nettype none

module dpcmdq_recon #(
    parameter int unsigned MAX_CHANNELS = 1024,
    parameter int unsigned SCALE_DEPTH  = 1024
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire dpcmdq_pkg::elem_t   iss,
    input  wire dpcmdq_pkg::scale_wr_t scale_wr,
    input  wire                      res_ready,
    output logic                     adv,
    output logic                     res_valid,
    output dpcmdq_pkg::result_t      res
);

    localparam int unsigned SAW = (SCALE_DEPTH > 1) ? $clog2(SCALE_DEPTH) : 1;
    localparam int unsigned CAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [31:0]        scale_mem [SCALE_DEPTH];
    logic signed [31:0] prev_mem  [MAX_CHANNELS];

    logic [31:0]        scale_rd_reg;
    logic signed [31:0] prev_rd_reg;

    logic               s1_valid_reg;
    dpcmdq_pkg::elem_t  s1_reg;

    logic               s2_valid_reg;
    dpcmdq_pkg::elem_t  s2_reg;
    logic signed [40:0] s2_prod_reg;
    logic signed [31:0] s2_prev_reg;

    logic                               hist0_valid_reg;
    logic                               hist1_valid_reg;
    logic [dpcmdq_pkg::POS_W-1:0]       hist0_ch_reg;
    logic [dpcmdq_pkg::POS_W-1:0]       hist1_ch_reg;
    logic signed [31:0]                 hist0_val_reg;
    logic signed [31:0]                 hist1_val_reg;

    logic                out_valid_reg;
    dpcmdq_pkg::result_t out_reg;

    logic [31:0]        scale_eff;
    logic signed [40:0] prod_s1;
    logic signed [31:0] pred_fwd;
    logic signed [31:0] pred;
    logic signed [41:0] sum;
    logic signed [31:0] recon_val;

    assign adv       = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // scale table: written by scale items, read on element issue
    always_ff @(posedge clk)
    begin
        if (scale_wr.we)
        begin
            scale_mem[SAW'(scale_wr.idx)] <= scale_wr.value;
        end
        if (iss.valid)
        begin
            scale_rd_reg <= scale_mem[SAW'(iss.scale_idx)];
        end
    end

    // previous reconstruction per channel
    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            prev_mem[CAW'(s2_reg.ch)] <= recon_val;
        end
        if (iss.valid)
        begin
            prev_rd_reg <= prev_mem[CAW'(iss.ch)];
        end
    end

    // stage 1: multiply code by scale
    always_comb
    begin
        scale_eff = s1_reg.scale_zero ? 32'd0 : scale_rd_reg;
        prod_s1   = $signed(s1_reg.code) * $signed({1'b0, scale_eff});
    end

    // stage 2: forward recent write-backs, add, saturate
    always_comb
    begin
        if (hist0_valid_reg && hist0_ch_reg == s2_reg.ch)
        begin
            pred_fwd = hist0_val_reg;
        end
        else if (hist1_valid_reg && hist1_ch_reg == s2_reg.ch)
        begin
            pred_fwd = hist1_val_reg;
        end
        else
        begin
            pred_fwd = s2_prev_reg;
        end
        pred = s2_reg.use_pred ? pred_fwd : 32'sd0;
        sum  = {{10{pred[31]}}, pred} + {s2_prod_reg[40], s2_prod_reg};
        if (sum[41:31] != {11{sum[41]}})
        begin
            recon_val = sum[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            recon_val = sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            hist0_valid_reg <= 1'b0;
            hist1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= iss.valid;
            s2_valid_reg    <= s1_valid_reg;
            out_valid_reg   <= s2_valid_reg;
            hist0_valid_reg <= s2_valid_reg;
            hist1_valid_reg <= hist0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg              <= iss;
            s2_reg              <= s1_reg;
            s2_prod_reg         <= prod_s1;
            s2_prev_reg         <= prev_rd_reg;
            hist0_ch_reg        <= s2_reg.ch;
            hist0_val_reg       <= recon_val;
            hist1_ch_reg        <= hist0_ch_reg;
            hist1_val_reg       <= hist0_val_reg;
            out_reg.recon       <= recon_val;
            out_reg.tok         <= s2_reg.tok;
            out_reg.ch          <= s2_reg.ch;
            out_reg.last_run    <= s2_reg.last_run;
            out_reg.last_tensor <= s2_reg.last_tensor;
        end
    end

endmodule

`default_nettype wire

/* src/dpcm_int_packed_dequantizer_unit.sv */
// ============================================================================
// dpcm_int_packed_dequantizer_unit
// Dequantizes packed int8 / int4 codes against a scale table, with optional
// per-channel delta reconstruction, saturated signed Q16.16 output.
// ============================================================================
//
//  channel   dir   handshake                 content
//  s_axis    in    s_axis_tvalid/tready      scale writes, payload bytes, restart
//  m_axis    out   m_axis_tvalid/tready      one reconstructed element per item
//  cfg       in    cfg_valid/cfg_ready       register index and write data
//
//  8-bit mode takes one byte per cycle unless m_axis stalls; 4-bit mode drops
//  s_axis_tready while a byte's high nibble issues, unless the pad nibble is dropped.
//  One element per cycle flows through the single multiplier and output register.
//  Each element passes registers s1, s2 and out; a high nibble first waits in hi_reg.
//  Reset clears control state only; scale and prediction memories are not
//  cleared and hold garbage until written. No clearing pass.
//  a held result with m_axis_tready low freezes the pipeline and drops s_axis_tready.
`default_nettype none

module dpcm_int_packed_dequantizer_unit #(
    parameter int unsigned MAX_CHANNELS = 1024,
    parameter int unsigned SCALE_DEPTH  = 1024
) (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [55:0] s_axis_tdata,   // scale_index, scale_value, payload_byte
    input  wire  [1:0]  s_axis_tuser,   // cmd

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // recon_value, token_index, channel_index
    output logic        m_axis_tlast,   // last_in_run
    output logic        m_axis_tuser,   // last_of_tensor

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [10:0] cfg_data
);

    localparam int unsigned PW = dpcmdq_pkg::POS_W;

    logic          four_bit_reg;
    logic          delta_reg;
    logic          per_ch_reg;
    logic [PW-1:0] e_last_reg;
    logic [PW-1:0] t_last_reg;

    logic [PW-1:0] ch_reg;
    logic [PW-1:0] ch_next;
    logic [PW-1:0] tok_reg;
    logic [PW-1:0] tok_next;
    logic          pend_reg;
    logic          pend_next;
    logic [3:0]    hi_reg;
    logic [3:0]    hi_next;

    logic [10:0]   cfg_clamp;
    logic [10:0]   e_clamp;

    logic            adv;
    logic            in_fire;
    dpcmdq_pkg::cmd_t in_cmd;
    logic [PW-1:0]   in_scale_idx;
    logic [31:0]     in_scale_val;
    logic [7:0]      in_byte;

    logic            stale;
    logic [PW-1:0]   cur_ch;
    logic [PW-1:0]   cur_tok;
    logic            ch_end;
    logic            at_last;

    dpcmdq_pkg::elem_t     iss;
    dpcmdq_pkg::scale_wr_t scale_wr;
    dpcmdq_pkg::result_t   res;
    logic                  res_valid;

    assign in_scale_idx = s_axis_tdata[9:0];
    assign in_scale_val = s_axis_tdata[41:10];
    assign in_byte      = s_axis_tdata[49:42];
    assign in_cmd       = dpcmdq_pkg::cmd_t'(s_axis_tuser);

    assign s_axis_tready = adv && !pend_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // shape clamp on config write
    always_comb
    begin
        if (cfg_data == 11'd0)
        begin
            cfg_clamp = 11'd1;
        end
        else if (cfg_data > dpcmdq_pkg::POS_LIMIT)
        begin
            cfg_clamp = dpcmdq_pkg::POS_LIMIT;
        end
        else
        begin
            cfg_clamp = cfg_data;
        end
        e_clamp = cfg_clamp;
        if (32'(cfg_clamp) > 32'(MAX_CHANNELS))
        begin
            e_clamp = 11'(MAX_CHANNELS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg <= 1'b0;
            delta_reg    <= 1'b0;
            per_ch_reg   <= 1'b0;
            e_last_reg   <= '0;
            t_last_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (dpcmdq_pkg::cfg_idx_t'(cfg_index))
                dpcmdq_pkg::CFG_FOUR_BIT:    four_bit_reg <= cfg_data[0];
                dpcmdq_pkg::CFG_DELTA:       delta_reg    <= cfg_data[0];
                dpcmdq_pkg::CFG_PER_CHANNEL: per_ch_reg   <= cfg_data[0];
                dpcmdq_pkg::CFG_ELEMS:       e_last_reg   <= PW'(e_clamp - 11'd1);
                dpcmdq_pkg::CFG_TOKENS:      t_last_reg   <= PW'(cfg_clamp - 11'd1);
                default: ;
            endcase
        end
    end

    // position of the next element
    always_comb
    begin
        stale   = (ch_reg > e_last_reg) || (tok_reg > t_last_reg);
        cur_ch  = stale ? '0 : ch_reg;
        cur_tok = stale ? '0 : tok_reg;
        ch_end  = (cur_ch == e_last_reg);
        at_last = ch_end && (cur_tok == t_last_reg);
    end

    // element issue and command decode
    always_comb
    begin
        iss            = '0;
        scale_wr       = '0;
        pend_next      = pend_reg;
        hi_next        = hi_reg;
        ch_next        = ch_reg;
        tok_next       = tok_reg;

        scale_wr.idx   = in_scale_idx;
        scale_wr.value = in_scale_val;

        iss.ch          = cur_ch;
        iss.tok         = cur_tok;
        iss.scale_idx   = per_ch_reg ? cur_ch : cur_tok;
        iss.scale_zero  = !(32'(iss.scale_idx) < 32'(SCALE_DEPTH));
        iss.use_pred    = delta_reg && (cur_tok != '0);
        iss.last_tensor = at_last;

        if (pend_reg)
        begin
            if (adv)
            begin
                iss.valid    = 1'b1;
                iss.code     = {{4{hi_reg[3]}}, hi_reg};
                iss.last_run = 1'b1;
                pend_next    = 1'b0;
            end
        end
        else if (in_fire)
        begin
            unique case (in_cmd)
                dpcmdq_pkg::CMD_WR_SCALE:
                begin
                    scale_wr.we = 32'(in_scale_idx) < 32'(SCALE_DEPTH);
                end
                dpcmdq_pkg::CMD_PAYLOAD:
                begin
                    iss.valid = 1'b1;
                    if (four_bit_reg)
                    begin
                        iss.code     = {{4{in_byte[3]}}, in_byte[3:0]};
                        iss.last_run = at_last;
                        if (!at_last)
                        begin
                            pend_next = 1'b1;
                            hi_next   = in_byte[7:4];
                        end
                    end
                    else
                    begin
                        iss.code     = in_byte;
                        iss.last_run = 1'b1;
                    end
                end
                dpcmdq_pkg::CMD_RESTART:
                begin
                    ch_next  = '0;
                    tok_next = '0;
                end
                default: ;
            endcase
        end

        if (iss.valid)
        begin
            if (ch_end)
            begin
                ch_next  = '0;
                tok_next = (cur_tok == t_last_reg) ? '0 : cur_tok + 1'b1;
            end
            else
            begin
                ch_next  = cur_ch + 1'b1;
                tok_next = cur_tok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg   <= '0;
            tok_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            ch_reg   <= ch_next;
            tok_reg  <= tok_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
    end

    dpcmdq_recon #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SCALE_DEPTH  (SCALE_DEPTH)
    ) u_recon (
        .clk       (clk),
        .rst_n     (rst_n),
        .iss       (iss),
        .scale_wr  (scale_wr),
        .res_ready (m_axis_tready),
        .adv       (adv),
        .res_valid (res_valid),
        .res       (res)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {4'd0, res.ch, res.tok, res.recon};
    assign m_axis_tlast  = res.last_run;
    assign m_axis_tuser  = res.last_tensor;

    // high nibble pending only right after a 4-bit payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> $past(in_fire && four_bit_reg))
        else $error("high nibble pending without a 4-bit payload");

    // an 8-bit payload never leaves a nibble pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_cmd == dpcmdq_pkg::CMD_PAYLOAD && !four_bit_reg) |=> !pend_reg)
        else $error("pending nibble after 8-bit payload");

    // end of tensor always closes the byte's run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("tensor end without end of run");

endmodule

`default_nettype wire

/* dv/dpcmdq_checker.sv */
// ============================================================================
// dpcmdq_checker
// Watches the config, input and output streams of the packed dpcm
// dequantizer and keeps its own copy of the scale table, the per-channel
// reconstruction memory and the position counters. Each accepted payload
// byte adds one or two predicted elements to a queue. Each element that
// leaves the block is compared field by field with the oldest prediction.
// ============================================================================
`default_nettype none

module dpcmdq_checker (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [55:0] s_axis_tdata,   // scale_index, scale_value, payload_byte
    input  wire  [1:0]  s_axis_tuser,   // cmd

    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [55:0] m_axis_tdata,   // recon_value, token_index, channel_index
    input  wire         m_axis_tlast,   // last_in_run
    input  wire         m_axis_tuser,   // last_of_tensor

    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [10:0] cfg_data,

    output int unsigned mismatches,
    output int unsigned pending
);

    localparam int unsigned DEPTH     = 1024;
    localparam int unsigned MAX_SHOWN = 10;
    localparam longint      RECON_MAX = 64'sd2147483647;
    localparam longint      RECON_MIN = -64'sd2147483648;

    logic                          four_bit;
    logic                          delta_on;
    logic                          chan_scales;
    logic [10:0]                   elems_cfg;
    logic [10:0]                   tokens_cfg;
    logic [31:0]                   scale_mem [DEPTH];
    logic signed [31:0]            recon_mem [DEPTH];
    int unsigned                   tok_pos;
    int unsigned                   ch_pos;
    dpcmdq_pkg::result_t           expected_elems [$];

    function automatic int unsigned shape_dim(logic [10:0] v);
        if (v == 11'd0)
            return 1;
        if (v > dpcmdq_pkg::POS_LIMIT)
            return 32'(dpcmdq_pkg::POS_LIMIT);
        return 32'(v);
    endfunction

    // one code through scale, prediction and saturation; advances the position
    function automatic dpcmdq_pkg::result_t reconstruct(logic signed [7:0] code);
        int unsigned         e_lim;
        int unsigned         t_lim;
        int unsigned         sel;
        longint              acc;
        dpcmdq_pkg::result_t r;
        e_lim = shape_dim(elems_cfg);
        t_lim = shape_dim(tokens_cfg);
        if (ch_pos >= e_lim || tok_pos >= t_lim)
        begin
            ch_pos  = 0;
            tok_pos = 0;
        end
        sel = chan_scales ? ch_pos : tok_pos;
        acc = longint'(code) * longint'({32'd0, scale_mem[sel]});
        if (delta_on && tok_pos != 0)
            acc = acc + longint'(recon_mem[ch_pos]);
        if (acc > RECON_MAX)
            acc = RECON_MAX;
        else if (acc < RECON_MIN)
            acc = RECON_MIN;
        recon_mem[ch_pos] = acc[31:0];
        r.recon       = acc[31:0];
        r.tok         = tok_pos[dpcmdq_pkg::POS_W-1:0];
        r.ch          = ch_pos[dpcmdq_pkg::POS_W-1:0];
        r.last_run    = 1'b0;
        r.last_tensor = (tok_pos == t_lim - 1) && (ch_pos == e_lim - 1);
        ch_pos++;
        if (ch_pos >= e_lim)
        begin
            ch_pos = 0;
            tok_pos++;
            if (tok_pos >= t_lim)
                tok_pos = 0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        dpcmdq_pkg::result_t got;
        dpcmdq_pkg::result_t want;
        dpcmdq_pkg::result_t elem;
        logic [7:0]          code_byte;
        if (!rst_n)
        begin
            four_bit    = 1'b0;
            delta_on    = 1'b0;
            chan_scales = 1'b0;
            elems_cfg   = 11'd1;
            tokens_cfg  = 11'd1;
            tok_pos     = 0;
            ch_pos      = 0;
            expected_elems.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.recon       = m_axis_tdata[31:0];
                got.tok         = m_axis_tdata[41:32];
                got.ch          = m_axis_tdata[51:42];
                got.last_run    = m_axis_tlast;
                got.last_tensor = m_axis_tuser;
                if (expected_elems.size() == 0)
                begin
                    if (mismatches < MAX_SHOWN)
                        $display("unexpected element: recon %0d tok %0d ch %0d last %b/%b",
                                 got.recon, got.tok, got.ch, got.last_run, got.last_tensor);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_elems.pop_front();
                    if (got.recon !== want.recon || got.tok !== want.tok ||
                        got.ch !== want.ch || got.last_run !== want.last_run ||
                        got.last_tensor !== want.last_tensor)
                    begin
                        if (mismatches < MAX_SHOWN)
                            $display("mismatch: exp %0d t%0d c%0d l%b/%b got %0d t%0d c%0d l%b/%b",
                                     want.recon, want.tok, want.ch, want.last_run,
                                     want.last_tensor, got.recon, got.tok, got.ch,
                                     got.last_run, got.last_tensor);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dpcmdq_pkg::CFG_FOUR_BIT:    four_bit    = cfg_data[0];
                    dpcmdq_pkg::CFG_DELTA:       delta_on    = cfg_data[0];
                    dpcmdq_pkg::CFG_PER_CHANNEL: chan_scales = cfg_data[0];
                    dpcmdq_pkg::CFG_ELEMS:       elems_cfg   = cfg_data;
                    dpcmdq_pkg::CFG_TOKENS:      tokens_cfg  = cfg_data;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                code_byte = s_axis_tdata[49:42];
                case (s_axis_tuser)
                    dpcmdq_pkg::CMD_WR_SCALE:
                        scale_mem[s_axis_tdata[9:0]] = s_axis_tdata[41:10];
                    dpcmdq_pkg::CMD_RESTART:
                    begin
                        tok_pos = 0;
                        ch_pos  = 0;
                    end
                    dpcmdq_pkg::CMD_PAYLOAD:
                    begin
                        if (!four_bit)
                            elem = reconstruct(code_byte);
                        else
                        begin
                            elem = reconstruct({{4{code_byte[3]}}, code_byte[3:0]});
                            // pad nibble is dropped once the tensor ends
                            if (!elem.last_tensor)
                            begin
                                expected_elems = {expected_elems, elem};
                                elem = reconstruct({{4{code_byte[7]}}, code_byte[7:4]});
                            end
                        end
                        elem.last_run = 1'b1;
                        expected_elems = {expected_elems, elem};
                    end
                    default: ;
                endcase
            end

            pending <= expected_elems.size();
        end
    end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ============================================================================
// tb_top
// Drives the packed dpcm dequantizer with scale writes, packed payload bytes,
// counter restarts and unused commands under a series of shape and mode
// settings, with random idle cycles on both streams, a long output stall and
// a full drain. The checker beside the block predicts and compares every
// element; this module makes stimulus and reports the verdict.
// ============================================================================
`default_nettype none

module tb_top;

    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int unsigned IDLE_PCT     = 12;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned FLUSH_CYCLES = 6;
    localparam int unsigned PHASES       = 14;
    localparam int unsigned PHASE_ITEMS  = 95;
    localparam int unsigned HOLD_PHASE   = 5;
    localparam int unsigned QUIET_PHASE  = 9;
    localparam int unsigned DRAIN_PHASE  = 11;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // scale_index, scale_value, payload_byte
    logic [1:0]  s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // recon_value, token_index, channel_index
    logic        m_axis_tlast;   // last_in_run
    logic        m_axis_tuser;   // last_of_tensor
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [10:0] cfg_data;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned cycle_count = 0;
    bit          scale_valid [1024];
    bit          gaps_on;
    bit          hold_pending;

    dpcm_int_packed_dequantizer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    dpcmdq_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // output side: random back-pressure, or one long hold-off on request
    initial
    begin : sink
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(32'h0002_0000);
            2:       return 32'h0000_0100 << $urandom_range(16);
            default: return $urandom_range(32'h0000_FFFF);
        endcase
    endfunction

    // leaves tvalid high after the item is taken
    task automatic push_item(logic [1:0] cmd, logic [9:0] sidx, logic [31:0] sval,
                             logic [7:0] pbyte);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'd0, pbyte, sval, sidx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (cmd == dpcmdq_pkg::CMD_WR_SCALE)
            scale_valid[sidx] = 1'b1;
    endtask

    // stop sending, wait for every element, then let the pipeline empty
    task automatic settle();
        int unsigned quiet;
        s_axis_tvalid <= 1'b0;
        quiet = 0;
        while (quiet < FLUSH_CYCLES)
        begin
            @(posedge clk);
            quiet = (m_axis_tready && pending == 0) ? quiet + 1 : 0;
        end
    endtask

    task automatic write_reg(dpcmdq_pkg::cfg_idx_t idx, logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic start_phase(bit four, bit delta, bit perch, logic [10:0] elems,
                               logic [10:0] tokens, bit restart);
        int unsigned need;
        settle();
        write_reg(dpcmdq_pkg::CFG_FOUR_BIT, {10'd0, four});
        write_reg(dpcmdq_pkg::CFG_DELTA, {10'd0, delta});
        write_reg(dpcmdq_pkg::CFG_PER_CHANNEL, {10'd0, perch});
        write_reg(dpcmdq_pkg::CFG_ELEMS, elems);
        write_reg(dpcmdq_pkg::CFG_TOKENS, tokens);
        cfg_valid <= 1'b0;
        // every scale entry the new shape can reach gets written first
        need = perch ? 32'(elems) : 32'(tokens);
        if (need == 0)
            need = 1;
        if (need > 1024)
            need = 1024;
        for (int i = 0; i < need; i++)
            if (!scale_valid[i])
                push_item(dpcmdq_pkg::CMD_WR_SCALE, 10'(i), pick_scale(), 8'($urandom));
        if (restart)
            push_item(dpcmdq_pkg::CMD_RESTART, 10'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic run_traffic(int unsigned count);
        int unsigned done;
        int unsigned roll;
        logic [7:0]  code_byte;
        done = 0;
        while (done < count)
        begin
            roll = $urandom_range(99);
            if (roll < 76)
            begin
                code_byte = 8'($urandom);
                if ($urandom_range(7) == 0)
                    case ($urandom_range(3))
                        0:       code_byte = 8'h80;
                        1:       code_byte = 8'h7F;
                        2:       code_byte = 8'h88;
                        default: code_byte = 8'h77;
                    endcase
                push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'($urandom), $urandom, code_byte);
            end
            else if (roll < 87)
                push_item(dpcmdq_pkg::CMD_WR_SCALE,
                          ($urandom_range(1) != 0) ? 10'($urandom_range(15)) : 10'($urandom),
                          pick_scale(), 8'($urandom));
            else if (roll < 94)
                push_item(dpcmdq_pkg::CMD_RESTART, 10'($urandom), $urandom, 8'($urandom));
            else
            begin
                push_item(CMD_UNUSED, 10'($urandom), $urandom, 8'($urandom));
                continue;
            end
            done++;
        end
    endtask

    initial
    begin : stimulus
        bit          four;
        bit          delta;
        bit          perch;
        logic [10:0] elems;
        logic [10:0] tokens;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        gaps_on      = 1'b1;
        hold_pending = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturation both ways, delta across tokens, int8 extremes
        push_item(dpcmdq_pkg::CMD_WR_SCALE, 10'd0, 32'hFFFF_FFFF, 8'h00);
        push_item(dpcmdq_pkg::CMD_WR_SCALE, 10'd1, 32'h0001_0000, 8'hFF);
        start_phase(1'b0, 1'b1, 1'b1, 11'd2, 11'd3, 1'b1);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'h3FF, 32'hFFFF_FFFF, 8'h80);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'h000, 32'h0000_0000, 8'h7F);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'h3FF, 32'h0000_0000, 8'h7F);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'h000, 32'hFFFF_FFFF, 8'h00);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'h155, 32'hAAAA_AAAA, 8'hFF);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'h2AA, 32'h5555_5555, 8'h01);

        // int4 nibble extremes, odd tensor drops the pad nibble
        start_phase(1'b1, 1'b0, 1'b0, 11'd3, 11'd1, 1'b1);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'($urandom), $urandom, 8'h87);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'($urandom), $urandom, 8'hF0);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'($urandom), $urandom, 8'h12);
        push_item(CMD_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 8'hFF);

        // shrinking the row leaves the channel position stale
        start_phase(1'b1, 1'b0, 1'b0, 11'd1, 11'd2, 1'b0);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'($urandom), $urandom, 8'h3C);
        push_item(dpcmdq_pkg::CMD_RESTART, 10'h3FF, 32'hFFFF_FFFF, 8'hFF);

        // out-of-range shape values clamp to the limits
        start_phase(1'b0, 1'b1, 1'b1, 11'd0, 11'd2047, 1'b1);
        push_item(dpcmdq_pkg::CMD_WR_SCALE, 10'h3FF, 32'h0000_0000, 8'h00);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'($urandom), $urandom, 8'h40);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'($urandom), $urandom, 8'hC0);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'($urandom), $urandom, 8'h7F);
        start_phase(1'b1, 1'b1, 1'b0, 11'd2047, 11'd0, 1'b1);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'($urandom), $urandom, 8'h88);
        push_item(dpcmdq_pkg::CMD_PAYLOAD, 10'($urandom), $urandom, 8'h77);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            four   = 1'($urandom_range(1));
            delta  = 1'($urandom_range(1));
            perch  = 1'($urandom_range(1));
            elems  = 11'($urandom_range(12, 1));
            tokens = 11'($urandom_range(6, 1));
            if (ph == 3)
            begin
                elems  = 11'd1024;
                tokens = 11'($urandom_range(3, 1));
                perch  = 1'b0;
            end
            if (ph == 7)
            begin
                elems  = 11'($urandom_range(3, 1));
                tokens = 11'd1024;
                perch  = 1'b1;
            end
            gaps_on = (ph != QUIET_PHASE);
            start_phase(four, delta, perch, elems, tokens, 1'b1);
            run_traffic(PHASE_ITEMS / 2);
            if (ph == HOLD_PHASE)
                hold_pending = 1'b1;
            if (ph == DRAIN_PHASE)
                settle();
            run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
        end
        gaps_on = 1'b1;

        settle();
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
